>>> rtl/rrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Read request coalescer package
// Shared types, widths and codes of the read request coalescer.
// ----------------------------------------------------------------------------
package rrc_pkg;

  localparam int SRC_W  = 16;
  localparam int OFS_W  = 48;
  localparam int GAP_W  = 32;
  localparam int AMP_W  = 16;
  localparam int NUM_W  = 32;
  localparam int PROD_W = OFS_W + AMP_W;
  localparam int KIND_W = 2;
  localparam int CFG_W  = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam int RES_SLOTS = 3;
  localparam int RCNT_W    = 2;

  localparam logic [KIND_W-1:0] KIND_PLACE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WINDOW  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OVERLAP = 2'd2;

  localparam logic REG_MAX_GAP = 1'b0;
  localparam logic REG_MAX_AMP = 1'b1;

  localparam logic [OFS_W-1:0] OFS_MAX = {OFS_W{1'b1}};

  typedef struct packed {
    logic [GAP_W-1:0] max_gap;
    logic [AMP_W-1:0] max_amp;
  } rrc_cfg_t;

  typedef struct packed {
    logic [SRC_W-1:0]  src_id;
    logic [OFS_W-1:0]  src_pos;
    logic [OFS_W-1:0]  dst_pos;
    logic [OFS_W-1:0]  length;
    logic              final_segment;
    logic [OFS_W-1:0]  seg_end;
    logic [PROD_W-1:0] amp_len;
  } rrc_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SRC_W-1:0]  window_source;
    logic [OFS_W-1:0]  start_offset;
    logic [OFS_W-1:0]  dest_offset;
    logic [OFS_W-1:0]  byte_count;
    logic [OFS_W-1:0]  payload_total;
    logic [NUM_W-1:0]  window_number;
    logic [OFS_W-1:0]  win_offset;
    logic              last_of_run;
  } rrc_result_t;

endpackage
`default_nettype wire

>>> rtl/read_request_coalescer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Read request coalescer
// Merges sorted copy segments into read windows and reports placements,
// window descriptors and overlap errors.
// ----------------------------------------------------------------------------
// A request passes the front stage register, the queue and the result buffer.
// Throughput: one request per cycle while each gives at most one result and the
// output is ready; the single output port drains the result buffer, and the
// window logic takes a request only when the buffer is empty or its one result drains.
// A write of the amplification limit stalls the window logic while the payload product is rescaled.
// Reset clears the open window, the window number and all buffers.
module read_request_coalescer_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [rrc_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [rrc_pkg::SRC_W-1:0]   in_source_index,
  input  wire logic [rrc_pkg::OFS_W-1:0]   in_src_offset,
  input  wire logic [rrc_pkg::OFS_W-1:0]   in_dst_offset,
  input  wire logic [rrc_pkg::OFS_W-1:0]   in_length,
  input  wire logic                        in_final_segment,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [rrc_pkg::KIND_W-1:0]       out_kind,
  output logic [rrc_pkg::SRC_W-1:0]        out_window_source,
  output logic [rrc_pkg::OFS_W-1:0]        out_start_offset,
  output logic [rrc_pkg::OFS_W-1:0]        out_dest_offset,
  output logic [rrc_pkg::OFS_W-1:0]        out_byte_count,
  output logic [rrc_pkg::OFS_W-1:0]        out_payload_total,
  output logic [rrc_pkg::NUM_W-1:0]        out_window_number,
  output logic [rrc_pkg::OFS_W-1:0]        out_offset_in_window,
  output logic                             out_last_of_run
);

  logic [rrc_pkg::GAP_W-1:0]  max_gap_r;
  logic [rrc_pkg::AMP_W-1:0]  max_amp_r;
  rrc_pkg::rrc_cfg_t          cfg;
  logic                       amp_load;
  logic                       push_valid;
  logic                       push_ready;
  rrc_pkg::rrc_item_t         push_item;
  logic                       q_valid;
  logic                       q_pop;
  rrc_pkg::rrc_item_t         q_item;
  rrc_pkg::rrc_result_t       result;

  assign cfg         = {max_gap_r, max_amp_r};
  assign amp_load    = cfg_we && (cfg_index == rrc_pkg::REG_MAX_AMP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_gap_r <= '0;
      max_amp_r <= rrc_pkg::AMP_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == rrc_pkg::REG_MAX_GAP) begin
        max_gap_r <= cfg_wdata[rrc_pkg::GAP_W-1:0];
      end else begin
        max_amp_r <= cfg_wdata[rrc_pkg::AMP_W-1:0];
      end
    end
  end

  rrc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .max_amp          (max_amp_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_source_index  (in_source_index),
    .in_src_offset    (in_src_offset),
    .in_dst_offset    (in_dst_offset),
    .in_length        (in_length),
    .in_final_segment (in_final_segment),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_item        (push_item)
  );

  rrc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  rrc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .amp_load   (amp_load),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (result)
  );

  assign out_kind             = result.kind;
  assign out_window_source    = result.window_source;
  assign out_start_offset     = result.start_offset;
  assign out_dest_offset      = result.dest_offset;
  assign out_byte_count       = result.byte_count;
  assign out_payload_total    = result.payload_total;
  assign out_window_number    = result.window_number;
  assign out_offset_in_window = result.win_offset;
  assign out_last_of_run      = result.last_of_run;

endmodule
`default_nettype wire

>>> rtl/rrc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Read request coalescer front stage
// Registers each request with its saturated end offset and its length scaled
// by the amplification limit, then hands it to the queue.
// ----------------------------------------------------------------------------
module rrc_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [rrc_pkg::AMP_W-1:0]   max_amp,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [rrc_pkg::SRC_W-1:0]   in_source_index,
  input  wire logic [rrc_pkg::OFS_W-1:0]   in_src_offset,
  input  wire logic [rrc_pkg::OFS_W-1:0]   in_dst_offset,
  input  wire logic [rrc_pkg::OFS_W-1:0]   in_length,
  input  wire logic                        in_final_segment,
  output logic                             push_valid,
  input  wire logic                        push_ready,
  output rrc_pkg::rrc_item_t               push_item
);

  logic                           stage_v_r;
  logic                           stage_v_nxt;
  rrc_pkg::rrc_item_t             stage_r;
  rrc_pkg::rrc_item_t             stage_nxt;
  logic                           in_fire;
  logic [rrc_pkg::OFS_W:0]        end_sum;

  assign in_fire    = in_valid && in_ready;
  assign in_ready   = !stage_v_r || push_ready;
  assign push_valid = stage_v_r;
  assign push_item  = stage_r;

  always_comb begin
    end_sum                 = {1'b0, in_src_offset} + {1'b0, in_length};
    stage_nxt.src_id        = in_source_index;
    stage_nxt.src_pos       = in_src_offset;
    stage_nxt.dst_pos       = in_dst_offset;
    stage_nxt.length        = in_length;
    stage_nxt.final_segment = in_final_segment;
    stage_nxt.seg_end       = end_sum[rrc_pkg::OFS_W] ? rrc_pkg::OFS_MAX
                                                      : end_sum[rrc_pkg::OFS_W-1:0];
    stage_nxt.amp_len       = rrc_pkg::PROD_W'(max_amp) * rrc_pkg::PROD_W'(in_length);
    stage_v_nxt             = in_fire || (stage_v_r && !push_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_r <= stage_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rrc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Read request coalescer queue
// Short first-in first-out buffer between the front stage and the window logic.
// ----------------------------------------------------------------------------
module rrc_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push_valid,
  output logic                     push_ready,
  input  wire rrc_pkg::rrc_item_t  push_item,
  output logic                     pop_valid,
  input  wire logic                pop,
  output rrc_pkg::rrc_item_t       pop_item
);

  rrc_pkg::rrc_item_t              mem_r [rrc_pkg::QUEUE_DEPTH];
  logic [rrc_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [rrc_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [rrc_pkg::QCNT_W-1:0]      cnt_r;
  logic [rrc_pkg::QCNT_W-1:0]      cnt_nxt;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = cnt_r != rrc_pkg::QCNT_W'(rrc_pkg::QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rrc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Read request coalescer window logic
// Holds the open read window, decides merge, new window or overlap for each
// request, and drains up to three results through a small output buffer.
// ----------------------------------------------------------------------------
module rrc_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rrc_pkg::rrc_cfg_t   cfg,
  input  wire logic                amp_load,
  input  wire logic                q_valid,
  output logic                     q_pop,
  input  wire rrc_pkg::rrc_item_t  q_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output rrc_pkg::rrc_result_t     out_result
);

  logic                            open_r;
  logic [rrc_pkg::SRC_W-1:0]       src_r;
  logic [rrc_pkg::OFS_W-1:0]       start_r;
  logic [rrc_pkg::OFS_W-1:0]       end_r;
  logic [rrc_pkg::OFS_W-1:0]       pay_r;
  logic [rrc_pkg::PROD_W-1:0]      amp_pay_r;
  logic [rrc_pkg::NUM_W-1:0]       wc_r;
  logic                            pend_r;
  rrc_pkg::rrc_result_t            slot_r [rrc_pkg::RES_SLOTS];
  logic [rrc_pkg::RCNT_W-1:0]      cnt_r;

  logic                            open_nxt;
  logic [rrc_pkg::SRC_W-1:0]       src_nxt;
  logic [rrc_pkg::OFS_W-1:0]       start_nxt;
  logic [rrc_pkg::OFS_W-1:0]       end_nxt;
  logic [rrc_pkg::OFS_W-1:0]       pay_nxt;
  logic [rrc_pkg::PROD_W-1:0]      amp_pay_nxt;
  logic [rrc_pkg::NUM_W-1:0]       wc_nxt;
  rrc_pkg::rrc_result_t            slot_nxt [rrc_pkg::RES_SLOTS];
  logic [rrc_pkg::RCNT_W-1:0]      cnt_nxt;

  logic                            fire;
  logic                            decide;
  logic                            len_nz;
  logic                            same;
  logic                            overlap;
  logic [rrc_pkg::OFS_W-1:0]       gap;
  logic                            gap_ok;
  logic [rrc_pkg::OFS_W-1:0]       cand_len;
  logic [rrc_pkg::OFS_W:0]         pay_sum;
  logic [rrc_pkg::OFS_W-1:0]       cand_pay;
  logic [rrc_pkg::PROD_W:0]        prod_sum;
  logic                            amp_ok;
  logic                            merge;
  logic                            start_new;
  logic                            close_a;
  logic                            open_b;
  logic                            flush;
  logic [rrc_pkg::NUM_W-1:0]       wc_b;
  logic [rrc_pkg::SRC_W-1:0]       new_src;
  logic [rrc_pkg::OFS_W-1:0]       new_start;
  logic [rrc_pkg::OFS_W-1:0]       new_end;
  logic [rrc_pkg::OFS_W-1:0]       new_pay;
  logic [rrc_pkg::PROD_W-1:0]      new_amp;
  rrc_pkg::rrc_result_t            res_a;
  rrc_pkg::rrc_result_t            res_b;
  rrc_pkg::rrc_result_t            res_c;

  assign out_valid  = cnt_r != '0;
  assign out_result = slot_r[0];
  assign fire       = out_valid && out_ready;
  assign decide     = q_valid && !pend_r &&
                      ((cnt_r == '0) || ((cnt_r == 2'd1) && out_ready));
  assign q_pop      = decide;

  always_comb begin
    len_nz    = |q_item.length;
    same      = open_r && (q_item.src_id == src_r);
    overlap   = len_nz && same && (q_item.src_pos < end_r);
    gap       = q_item.src_pos - end_r;
    gap_ok    = gap <= {{(rrc_pkg::OFS_W-rrc_pkg::GAP_W){1'b0}}, cfg.max_gap};
    cand_len  = q_item.seg_end - start_r;
    pay_sum   = {1'b0, pay_r} + {1'b0, q_item.length};
    cand_pay  = pay_sum[rrc_pkg::OFS_W] ? rrc_pkg::OFS_MAX : pay_sum[rrc_pkg::OFS_W-1:0];
    prod_sum  = {1'b0, amp_pay_r} + {1'b0, q_item.amp_len};
    amp_ok    = (cfg.max_amp != '0) &&
                (pay_sum[rrc_pkg::OFS_W] ||
                 ({{(rrc_pkg::PROD_W+1-rrc_pkg::OFS_W){1'b0}}, cand_len} <= prod_sum));
    merge     = len_nz && same && !overlap && gap_ok && amp_ok;
    start_new = len_nz && !merge && !overlap;
    close_a   = start_new && open_r;
    wc_b      = wc_r + {{(rrc_pkg::NUM_W-1){1'b0}}, close_a};
    open_b    = len_nz || open_r;
    flush     = q_item.final_segment && open_b && !overlap;

    new_src   = start_new ? q_item.src_id : src_r;
    new_start = start_new ? q_item.src_pos : start_r;
    new_end   = (start_new || merge) ? q_item.seg_end : end_r;
    new_pay   = start_new ? q_item.length : (merge ? cand_pay : pay_r);
    new_amp   = start_new ? q_item.amp_len
                          : (merge ? prod_sum[rrc_pkg::PROD_W-1:0] : amp_pay_r);

    res_a.kind             = rrc_pkg::KIND_WINDOW;
    res_a.window_source    = src_r;
    res_a.start_offset     = start_r;
    res_a.dest_offset      = '0;
    res_a.byte_count       = end_r - start_r;
    res_a.payload_total    = pay_r;
    res_a.window_number    = wc_r;
    res_a.win_offset       = '0;
    res_a.last_of_run      = 1'b0;

    res_b.kind             = overlap ? rrc_pkg::KIND_OVERLAP : rrc_pkg::KIND_PLACE;
    res_b.window_source    = q_item.src_id;
    res_b.start_offset     = q_item.src_pos;
    res_b.dest_offset      = q_item.dst_pos;
    res_b.byte_count       = q_item.length;
    res_b.payload_total    = '0;
    res_b.window_number    = wc_b;
    res_b.win_offset       = overlap ? '0 : (q_item.src_pos - new_start);
    res_b.last_of_run      = !flush;

    res_c.kind             = rrc_pkg::KIND_WINDOW;
    res_c.window_source    = new_src;
    res_c.start_offset     = new_start;
    res_c.dest_offset      = '0;
    res_c.byte_count       = new_end - new_start;
    res_c.payload_total    = new_pay;
    res_c.window_number    = wc_b;
    res_c.win_offset       = '0;
    res_c.last_of_run      = 1'b1;
  end

  always_comb begin
    open_nxt    = open_r;
    src_nxt     = src_r;
    start_nxt   = start_r;
    end_nxt     = end_r;
    pay_nxt     = pay_r;
    amp_pay_nxt = amp_pay_r;
    wc_nxt      = wc_r;
    cnt_nxt     = cnt_r;
    slot_nxt[0] = slot_r[0];
    slot_nxt[1] = slot_r[1];
    slot_nxt[2] = slot_r[2];
    if (pend_r) begin
      amp_pay_nxt = rrc_pkg::PROD_W'(cfg.max_amp) * rrc_pkg::PROD_W'(pay_r);
    end
    if (decide) begin
      open_nxt    = open_b && !overlap && !flush;
      src_nxt     = new_src;
      start_nxt   = new_start;
      end_nxt     = new_end;
      pay_nxt     = new_pay;
      amp_pay_nxt = new_amp;
      wc_nxt      = wc_b + {{(rrc_pkg::NUM_W-1){1'b0}}, flush};
      cnt_nxt     = rrc_pkg::RCNT_W'(close_a) + rrc_pkg::RCNT_W'(len_nz)
                    + rrc_pkg::RCNT_W'(flush);
      slot_nxt[0] = close_a ? res_a : (len_nz ? res_b : res_c);
      slot_nxt[1] = close_a ? res_b : res_c;
      slot_nxt[2] = res_c;
    end else if (fire) begin
      cnt_nxt     = cnt_r - 1'b1;
      slot_nxt[0] = slot_r[1];
      slot_nxt[1] = slot_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      wc_r   <= '0;
      pend_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      open_r <= open_nxt;
      wc_r   <= wc_nxt;
      pend_r <= amp_load;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r     <= src_nxt;
    start_r   <= start_nxt;
    end_r     <= end_nxt;
    pay_r     <= pay_nxt;
    amp_pay_r <= amp_pay_nxt;
    slot_r[0] <= slot_nxt[0];
    slot_r[1] <= slot_nxt[1];
    slot_r[2] <= slot_nxt[2];
  end

endmodule
`default_nettype wire
